@@ sv/dsps_pkg.sv @@
// Shared types, codes and sizing constants for the date-sorted priority stack.
`timescale 1ns / 1ps
`default_nettype none

package dsps_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int OCC_W   = 5;
    localparam int STAT_W  = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_POP    = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [TAG_W-1:0]   tag;
    } rec_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic pop;
        rec_t rec;
    } cell_ctrl_t;

    function automatic logic [KEY_W-1:0] date_key(input rec_t r);
        date_key = {r.year, r.month, r.day};
    endfunction

endpackage

`default_nettype wire

@@ sv/dsps_ifs.sv @@
// Valid/ready channel interfaces for the command and result words.
`timescale 1ns / 1ps
`default_nettype none

interface dsps_cmd_if;
    import dsps_pkg::*;

    logic               valid;
    logic               ready;
    logic               cmd;
    logic [YEAR_W-1:0]  birth_year;
    logic [MONTH_W-1:0] birth_month;
    logic [DAY_W-1:0]   birth_day;
    logic [TAG_W-1:0]   record_tag;

    modport source (output valid, cmd, birth_year, birth_month, birth_day, record_tag,
                    input ready);
    modport sink   (input valid, cmd, birth_year, birth_month, birth_day, record_tag,
                    output ready);
endinterface

interface dsps_rsp_if;
    import dsps_pkg::*;

    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  head_year;
    logic [MONTH_W-1:0] head_month;
    logic [DAY_W-1:0]   head_day;
    logic [TAG_W-1:0]   head_tag;
    logic [OCC_W-1:0]   occupancy;
    logic [STAT_W-1:0]  status;

    modport source (output valid, head_year, head_month, head_day, head_tag, occupancy,
                    status, input ready);
    modport sink   (input valid, head_year, head_month, head_day, head_tag, occupancy,
                    status, output ready);
endinterface

`default_nettype wire

@@ sv/dsps_cell.sv @@
// One cell of the sorted chain: holds a record, compares, shifts up or down.
`timescale 1ns / 1ps
`default_nettype none

module dsps_cell
    import dsps_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       occupied,
    input  wire logic       lt_above,
    input  wire rec_t       rec_above,
    input  wire rec_t       rec_below,
    output logic            lt,
    output rec_t            rec
);

    rec_t rec_reg;
    rec_t rec_next;

    // Stored record sorts strictly before the incoming one.
    assign lt  = occupied && (date_key(rec_reg) < date_key(ctrl.rec));
    assign rec = rec_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.ins && !lt)
        begin
            rec_next = lt_above ? ctrl.rec : rec_above;
        end
        else if (ctrl.pop)
        begin
            rec_next = rec_below;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

endmodule

`default_nettype wire

@@ sv/date_sorted_priority_stack.sv @@
// Top level of the date-sorted priority stack: cell chain, count and result register.
//
// Usage: words arrive on cmd_ch (valid/ready). cmd 0 inserts a record
// (date plus tag) in date order, earliest at the top; among equal dates the
// newest insert lands nearest the top. cmd 1 pops the top record. Each
// accepted word yields exactly one result word on rsp_ch: the top record
// after the operation (zeros when empty), the occupancy and a status
// (ok, insert rejected because full, pop on empty).
// The result is registered and valid in the cycle after the command word is taken.
// Throughput: one word per cycle while the result side keeps rsp_ch.ready
// high. Every cell compares its record against the incoming date in
// parallel, and all cells shift toward their neighbors together.
// Stall: the result register holds while rsp_ch.ready is low, and cmd_ch
// ready drops until the pending result is taken; the cells change only on
// an accepted word, so the shown head stays stable.
// Reset: rst_n clears the record count and the result valid flag; cell
// contents are left as is and are never shown until written.
`timescale 1ns / 1ps
`default_nettype none

module date_sorted_priority_stack
    import dsps_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    dsps_cmd_if.sink    cmd_ch,
    dsps_rsp_if.source  rsp_ch
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic              accept;
    logic              full;
    logic              empty;
    cell_ctrl_t        ctrl;
    rec_t              new_rec;
    rec_t              head;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    status_t           status_reg;
    status_t           status_next;

    rec_t              cell_rec [DEPTH];
    logic [DEPTH-1:0]  cell_lt;

    // Accept a new word whenever the result slot is free or being drained.
    assign cmd_ch.ready = !rsp_valid_reg || rsp_ch.ready;
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    assign new_rec.year  = cmd_ch.birth_year;
    assign new_rec.month = cmd_ch.birth_month;
    assign new_rec.day   = cmd_ch.birth_day;
    assign new_rec.tag   = cmd_ch.record_tag;

    // Broadcast the operation to the chain; drop rejected ones.
    assign ctrl.ins = accept && (cmd_ch.cmd == CMD_INSERT) && !full;
    assign ctrl.pop = accept && (cmd_ch.cmd == CMD_POP) && !empty;
    assign ctrl.rec = new_rec;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic occ;
            logic lt_up;
            rec_t rec_up;
            rec_t rec_dn;

            assign occ = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_top
                // Nothing above the top cell: on an insert it takes the new record unless its own sorts earlier.
                assign lt_up  = 1'b1;
                assign rec_up = new_rec;
            end
            else
            begin : g_mid
                assign lt_up  = cell_lt[gi-1];
                assign rec_up = cell_rec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_bot
                // Bottom cell falls out of range on a pop; its content is don't-care.
                assign rec_dn = cell_rec[gi];
            end
            else
            begin : g_inner
                assign rec_dn = cell_rec[gi+1];
            end

            dsps_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occupied  (occ),
                .lt_above  (lt_up),
                .rec_above (rec_up),
                .rec_below (rec_dn),
                .lt        (cell_lt[gi]),
                .rec       (cell_rec[gi])
            );
        end
    endgenerate

    // Count and status.
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_ch.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            status_next    = STAT_OK;
            if (cmd_ch.cmd == CMD_INSERT)
            begin
                if (full)
                    status_next = STAT_FULL;
                else
                    count_next = count_reg + 1'b1;
            end
            else
            begin
                if (empty)
                    status_next = STAT_EMPTY;
                else
                    count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= STAT_OK;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
        end
    end

    // Head of the chain, zero when the store is empty.
    assign head = empty ? '0 : cell_rec[0];

    assign rsp_ch.valid      = rsp_valid_reg;
    assign rsp_ch.head_year  = head.year;
    assign rsp_ch.head_month = head.month;
    assign rsp_ch.head_day   = head.day;
    assign rsp_ch.head_tag   = head.tag;
    assign rsp_ch.occupancy  = OCC_W'(count_reg);
    assign rsp_ch.status     = status_reg;

    // Checks.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count beyond depth");

    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.pop |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_FULL)) |-> full)
        else $error("full status while store not full");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg == STAT_EMPTY)) |-> (empty && (head.tag == '0)))
        else $error("empty status with records present");

endmodule

`default_nettype wire

@@ tb/sv/date_sorted_priority_stack_tb.sv @@
// Self-checking testbench for the date-sorted priority stack.
`timescale 1ns / 1ps

module date_sorted_priority_stack_tb;
    import dsps_pkg::*;

    localparam int CELLS      = DEPTH_DEFAULT;
    localparam int IDLE_LIMIT = 2000;  // well above the longest legal quiet stretch
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 50;

    // One command word as the stack sees it.
    typedef struct packed {
        logic cmd;
        rec_t rec;
    } word_t;

    // One result word: head record, occupancy and status.
    typedef struct packed {
        rec_t             head;
        logic [OCC_W-1:0] occupancy;
        status_t          status;
    } head_report_t;

    // Directed table row; typed rows carry a hand-written result.
    typedef struct {
        word_t        w;
        bit           typed;
        head_report_t want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    dsps_cmd_if cmd_ch ();
    dsps_rsp_if rsp_ch ();

    date_sorted_priority_stack #(.DEPTH(CELLS)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .rsp_ch (rsp_ch)
    );

    // Shadow copy of the sorted store; cell 0 is the earliest date.
    rec_t         shadow_cells [CELLS];
    int           shadow_count;

    head_report_t pending_heads [$];
    dir_row_t     directed_rows [$];
    rec_t         tie_dates [4];

    int mismatches;
    int n_insert, n_pop, n_full, n_empty, peak_count, n_random;

    // Idle controls: when set, that side never pauses.
    bit src_steady;
    bit sink_steady;

    // Clock: 12 ns period.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", what, got, want));
    endtask

    // Advance the shadow store by one accepted word and return the head it shows.
    // Insert goes below every strictly earlier date, so equal dates stack newest-first.
    function automatic head_report_t predict_head(input word_t w);
        head_report_t r;
        int           pos;
        int           i;
        r.status = STAT_OK;
        if (w.cmd == CMD_INSERT)
        begin
            if (shadow_count >= CELLS)
                r.status = STAT_FULL;
            else
            begin
                pos = 0;
                while (pos < shadow_count &&
                       {shadow_cells[pos].year, shadow_cells[pos].month, shadow_cells[pos].day}
                       < {w.rec.year, w.rec.month, w.rec.day})
                    pos++;
                for (i = shadow_count; i > pos; i--)
                    shadow_cells[i] = shadow_cells[i-1];
                shadow_cells[pos] = w.rec;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                r.status = STAT_EMPTY;
            else
            begin
                for (i = 0; i + 1 < shadow_count; i++)
                    shadow_cells[i] = shadow_cells[i+1];
                shadow_count--;
            end
        end
        r.head      = (shadow_count > 0) ? shadow_cells[0] : '0;
        r.occupancy = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t plain_row(input logic c, input int y, input int m,
                                           input int d, input int t);
        dir_row_t row;
        row.w.cmd       = c;
        row.w.rec.year  = y[YEAR_W-1:0];
        row.w.rec.month = m[MONTH_W-1:0];
        row.w.rec.day   = d[DAY_W-1:0];
        row.w.rec.tag   = t[TAG_W-1:0];
        row.typed       = 1'b0;
        row.want        = '0;
        return row;
    endfunction

    function automatic dir_row_t typed_row(input logic c, input int y, input int m,
                                           input int d, input int t,
                                           input int hy, input int hm, input int hd,
                                           input int ht, input int occ, input status_t st);
        dir_row_t row;
        row                = plain_row(c, y, m, d, t);
        row.typed          = 1'b1;
        row.want.head.year  = hy[YEAR_W-1:0];
        row.want.head.month = hm[MONTH_W-1:0];
        row.want.head.day   = hd[DAY_W-1:0];
        row.want.head.tag   = ht[TAG_W-1:0];
        row.want.occupancy  = occ[OCC_W-1:0];
        row.want.status     = st;
        return row;
    endfunction

    // Drive one word, hold it until taken, then queue its expected head.
    // Valid is lowered only when a gap follows, so back-to-back words keep it high.
    task automatic send_word(input word_t w, input bit typed, input head_report_t want);
        int           gap;
        int           r;
        head_report_t model;
        gap = 0;
        if (!src_steady)
        begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 30);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.cmd         <= w.cmd;
        cmd_ch.birth_year  <= w.rec.year;
        cmd_ch.birth_month <= w.rec.month;
        cmd_ch.birth_day   <= w.rec.day;
        cmd_ch.record_tag  <= w.rec.tag;
        do @(posedge clk); while (!cmd_ch.ready);

        model = predict_head(w);
        pending_heads.push_back(typed ? want : model);
        if (w.cmd == CMD_INSERT)
            n_insert++;
        else
            n_pop++;
        if (model.status == STAT_FULL)
            n_full++;
        if (model.status == STAT_EMPTY)
            n_empty++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endtask

    // Result side: check every taken word against the oldest expectation,
    // then pick next cycle's ready (short stalls mostly, a few long ones).
    initial
    begin
        int           stall_left;
        int           r;
        head_report_t exp_head;
        stall_left   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                if (pending_heads.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    exp_head = pending_heads.pop_front();
                    check_field("head_year",  16'(rsp_ch.head_year),
                                16'(exp_head.head.year));
                    check_field("head_month", 16'(rsp_ch.head_month),
                                16'(exp_head.head.month));
                    check_field("head_day",   16'(rsp_ch.head_day),
                                16'(exp_head.head.day));
                    check_field("head_tag",   16'(rsp_ch.head_tag),
                                16'(exp_head.head.tag));
                    check_field("occupancy",  16'(rsp_ch.occupancy),
                                16'(exp_head.occupancy));
                    check_field("status",     16'(rsp_ch.status),
                                16'(exp_head.status));
                end
            end
            if (stall_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!sink_steady)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 12)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 15)
                        stall_left = $urandom_range(10, 30);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_heads.size());
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        int           ph;
        int           k;
        int           insert_pct;
        int           pct_by_phase [PHASES];
        word_t        w;
        head_report_t none;

        // Hold every input at a known value from time zero.
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.cmd         = CMD_INSERT;
        cmd_ch.birth_year  = '0;
        cmd_ch.birth_month = '0;
        cmd_ch.birth_day   = '0;
        cmd_ch.record_tag  = '0;
        src_steady         = 1'b0;
        sink_steady        = 1'b0;
        mismatches         = 0;
        n_insert = 0; n_pop = 0; n_full = 0; n_empty = 0; peak_count = 0; n_random = 0;
        shadow_count       = 0;
        none               = '0;

        // Dates that random inserts reuse so that ties occur often.
        tie_dates[0] = '{year: 12'd2000, month: 4'd6,  day: 5'd15, tag: '0};
        tie_dates[1] = '{year: 12'd2000, month: 4'd6,  day: 5'd16, tag: '0};
        tie_dates[2] = '{year: 12'd0,    month: 4'd0,  day: 5'd0,  tag: '0};
        tie_dates[3] = '{year: 12'hfff,  month: 4'hf,  day: 5'h1f, tag: '0};

        // Empty pop, extremes, equal dates, ignored pop fields.
        directed_rows.push_back(typed_row(CMD_POP, 0, 0, 0, 0, 0, 0, 0, 0, 0, STAT_EMPTY));
        directed_rows.push_back(typed_row(CMD_INSERT, 4095, 15, 31, 'hffff,
                                          4095, 15, 31, 'hffff, 1, STAT_OK));
        directed_rows.push_back(typed_row(CMD_INSERT, 0, 0, 0, 0, 0, 0, 0, 0, 2, STAT_OK));
        directed_rows.push_back(typed_row(CMD_INSERT, 0, 0, 0, 'h1234,
                                          0, 0, 0, 'h1234, 3, STAT_OK));
        directed_rows.push_back(typed_row(CMD_POP, 4095, 15, 31, 'hffff,
                                          0, 0, 0, 0, 2, STAT_OK));
        // Fill to capacity: ties, month 0 and 13, day 0, alternating bit patterns.
        directed_rows.push_back(plain_row(CMD_INSERT, 2024, 2, 29, 'h0101));
        directed_rows.push_back(plain_row(CMD_INSERT, 2024, 2, 28, 'h0102));
        directed_rows.push_back(plain_row(CMD_INSERT, 2024, 13, 5, 'h0103));
        directed_rows.push_back(plain_row(CMD_INSERT, 2024, 12, 0, 'h0104));
        directed_rows.push_back(plain_row(CMD_INSERT, 1, 1, 1, 'h0105));
        directed_rows.push_back(plain_row(CMD_INSERT, 4095, 15, 31, 'h0106));
        directed_rows.push_back(plain_row(CMD_INSERT, 2048, 8, 16, 'h0107));
        directed_rows.push_back(plain_row(CMD_INSERT, 1024, 4, 8, 'h0108));
        directed_rows.push_back(plain_row(CMD_INSERT, 2024, 2, 29, 'h0109));
        directed_rows.push_back(plain_row(CMD_INSERT, 0, 0, 1, 'h010a));
        directed_rows.push_back(plain_row(CMD_INSERT, 4095, 15, 30, 'h010b));
        directed_rows.push_back(plain_row(CMD_INSERT, 0, 1, 0, 'h010c));
        directed_rows.push_back(plain_row(CMD_INSERT, 1, 0, 0, 'h010d));
        directed_rows.push_back(plain_row(CMD_INSERT, 'haaa, 'ha, 'h15, 'ha5a5));
        // Store is full now: reject and keep the earliest record on top.
        directed_rows.push_back(typed_row(CMD_INSERT, 'h555, 5, 'ha, 'h5a5a,
                                          0, 0, 0, 0, CELLS, STAT_FULL));
        directed_rows.push_back(plain_row(CMD_POP, 0, 0, 0, 0));

        // Insert share per random phase: swing the count between empty and full.
        pct_by_phase = '{80, 50, 25, 70, 95, 15, 55, 60};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < directed_rows.size(); k++)
            send_word(directed_rows[k].w, directed_rows[k].typed, directed_rows[k].want);

        for (ph = 0; ph < PHASES; ph++)
        begin
            insert_pct  = pct_by_phase[ph];
            // Every fourth phase runs with no idling on either side.
            src_steady  = (ph % 4 == 1);
            sink_steady = (ph % 4 == 1);
            for (k = 0; k < PHASE_LEN; k++)
            begin
                w.cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_POP;
                if ($urandom_range(0, 9) < 3)
                    w.rec = tie_dates[$urandom_range(0, 3)];
                else
                begin
                    w.rec.year  = YEAR_W'($urandom_range(0, 4095));
                    w.rec.month = MONTH_W'($urandom_range(0, 15));
                    w.rec.day   = DAY_W'($urandom_range(0, 31));
                end
                w.rec.tag = TAG_W'($urandom_range(0, 65535));
                send_word(w, 1'b0, none);
                n_random++;
            end
        end
        cmd_ch.valid <= 1'b0;
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        // Drain: wait for every outstanding result, then wait on for stray result words.
        while (pending_heads.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Covered %0d directed and %0d random words: %0d inserts (%0d refused as full),",
                 directed_rows.size(), n_random, n_insert, n_full);
        $display("%0d pops (%0d on an empty store), peak occupancy %0d of %0d.",
                 n_pop, n_empty, peak_count, CELLS);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
